// File: src/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the golden-section search controller.
// ----------------------------------------------------------------------------
package gss_pkg;

   // Search phase: idle, waiting for the first low-probe fitness, running
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_RUN
   } phase_type;

   // Input item mode codes
   localparam logic MODE_START  = 1'b0;
   localparam logic MODE_REPORT = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOMAIN_MIN = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOMAIN_MAX = 1'b1;

   // Register reset values, signed Q16.16
   localparam logic [CSR_DATA_WIDTH-1:0] DOMAIN_MIN_RESET = 32'h0000_0000;
   localparam logic [CSR_DATA_WIDTH-1:0] DOMAIN_MAX_RESET = 32'h0001_0000;

   // Golden ratio fractions in Q0.16: 0.381966 and 0.618034
   localparam int GOLD_K_WIDTH = 16;
   localparam logic [GOLD_K_WIDTH-1:0] GOLD_K_LOW  = 16'd25032;
   localparam logic [GOLD_K_WIDTH-1:0] GOLD_K_HIGH = 16'd40504;

   // Control of the item held in the input register
   typedef struct packed {
      logic valid;
      logic mode;
   } item_ctrl_type;

endpackage

// File: src/gss_golden.sv
// ----------------------------------------------------------------------------
// gss_golden
// Golden-section point: lo + (|hi - lo| * K) >> 16, stepping below lo when
// the bracket is reversed. The product is truncated towards zero.
// ----------------------------------------------------------------------------
module gss_golden #(
   parameter int POINT_WIDTH = 32,
   parameter logic [15:0] SCALE = 16'd25032
) (
   input  logic signed [POINT_WIDTH-1:0] lo_point,
   input  logic signed [POINT_WIDTH-1:0] hi_point,
   output logic signed [POINT_WIDTH-1:0] gold_point
);
   import gss_pkg::*;

   localparam int PROD_WIDTH = POINT_WIDTH + GOLD_K_WIDTH;

   logic                   reversed;
   logic [POINT_WIDTH-1:0] span_mag;
   logic [PROD_WIDTH-1:0]  span_prod;
   logic [POINT_WIDTH-1:0] span_scaled;

   // Take the span as a magnitude, scale it, then step from the low end
   always_comb begin
      reversed    = hi_point < lo_point;
      span_mag    = reversed ? POINT_WIDTH'(lo_point - hi_point)
                             : POINT_WIDTH'(hi_point - lo_point);
      span_prod   = PROD_WIDTH'(span_mag) * PROD_WIDTH'(SCALE);
      span_scaled = span_prod[PROD_WIDTH-1:GOLD_K_WIDTH];
      gold_point  = reversed ? POINT_WIDTH'(lo_point - $signed(span_scaled))
                             : POINT_WIDTH'(lo_point + $signed(span_scaled));
   end

endmodule

// File: src/gss_in_stage.sv
// ----------------------------------------------------------------------------
// gss_in_stage
// Input register: holds one accepted item until the step stage takes it.
// ----------------------------------------------------------------------------
module gss_in_stage #(
   parameter int FITNESS_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic                             in_mode,
   input  logic signed [FITNESS_WIDTH-1:0]  in_fitness,
   input  logic                             take,
   output gss_pkg::item_ctrl_type           item,
   output logic signed [FITNESS_WIDTH-1:0]  item_fitness
);
   import gss_pkg::*;

   logic                            valid_ff;
   logic                            mode_ff;
   logic signed [FITNESS_WIDTH-1:0] fitness_ff;

   // Free slot, or the slot empties this cycle
   assign in_ready = !valid_ff || take;

   // Hold the control bit of the held transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   // Load the payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mode_ff    <= in_mode;
         fitness_ff <= in_fitness;
      end
   end

   assign item.valid   = valid_ff;
   assign item.mode    = mode_ff;
   assign item_fitness = fitness_ff;

endmodule

// File: src/gss_step.sv
// ----------------------------------------------------------------------------
// gss_step
// Search state, bracket update and result register. One held item is
// processed per cycle whenever the result register is free or draining.
// ----------------------------------------------------------------------------
module gss_step #(
   parameter int POINT_WIDTH   = 32,
   parameter int FITNESS_WIDTH = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_we,
   input  logic [gss_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [gss_pkg::CSR_DATA_WIDTH-1:0]           csr_wdata,
   input  gss_pkg::item_ctrl_type                       item,
   input  logic signed [FITNESS_WIDTH-1:0]              item_fitness,
   output logic                                         take,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [POINT_WIDTH-1:0]                rsp_probe_point,
   output logic signed [POINT_WIDTH-1:0]                rsp_best_point,
   output logic signed [FITNESS_WIDTH-1:0]              rsp_best_fitness,
   output logic                                         rsp_best_valid,
   output logic                                         rsp_report_ignored
);
   import gss_pkg::*;

   localparam logic signed [FITNESS_WIDTH-1:0] FIT_MAX = {1'b0, {(FITNESS_WIDTH-1){1'b1}}};

   // Configuration registers
   logic signed [CSR_DATA_WIDTH-1:0] domain_min_ff, domain_max_ff;

   // Search state
   logic signed [POINT_WIDTH-1:0]   lower_ff, lower_in, upper_ff, upper_in;
   logic signed [POINT_WIDTH-1:0]   low_probe_ff, low_probe_in;
   logic signed [POINT_WIDTH-1:0]   high_probe_ff, high_probe_in;
   logic signed [FITNESS_WIDTH-1:0] low_fit_ff, low_fit_in, high_fit_ff, high_fit_in;
   phase_type                       phase_ff, phase_in;
   logic                            pending_low_ff, pending_low_in;

   // Result register
   logic                            rsp_valid_ff;
   logic signed [POINT_WIDTH-1:0]   probe_ff, probe_in, best_pt_ff, best_pt_in;
   logic signed [FITNESS_WIDTH-1:0] best_fit_ff, best_fit_in;
   logic                            best_valid_ff, best_valid_in;
   logic                            ignored_ff, ignored_in;

   // Candidate points
   logic signed [POINT_WIDTH-1:0]   dom_lo, dom_hi;
   logic signed [POINT_WIDTH-1:0]   start_low, start_high, run_low, run_high;
   logic signed [FITNESS_WIDTH-1:0] cur_low_fit, cur_high_fit;
   logic                            low_wins;

   assign dom_lo = POINT_WIDTH'(domain_min_ff);
   assign dom_hi = POINT_WIDTH'(domain_max_ff);

   gss_golden #(.POINT_WIDTH(POINT_WIDTH), .SCALE(GOLD_K_LOW)) u_start_low (
      .lo_point(dom_lo), .hi_point(dom_hi), .gold_point(start_low)
   );
   gss_golden #(.POINT_WIDTH(POINT_WIDTH), .SCALE(GOLD_K_HIGH)) u_start_high (
      .lo_point(dom_lo), .hi_point(dom_hi), .gold_point(start_high)
   );
   // New low probe when the bracket shrinks from above
   gss_golden #(.POINT_WIDTH(POINT_WIDTH), .SCALE(GOLD_K_LOW)) u_run_low (
      .lo_point(lower_ff), .hi_point(high_probe_ff), .gold_point(run_low)
   );
   // New high probe when the bracket shrinks from below
   gss_golden #(.POINT_WIDTH(POINT_WIDTH), .SCALE(GOLD_K_HIGH)) u_run_high (
      .lo_point(low_probe_ff), .hi_point(upper_ff), .gold_point(run_high)
   );

   assign take = item.valid && (!rsp_valid_ff || rsp_ready);

   // Next state and result for the held transaction
   always_comb begin
      lower_in       = lower_ff;
      upper_in       = upper_ff;
      low_probe_in   = low_probe_ff;
      high_probe_in  = high_probe_ff;
      low_fit_in     = low_fit_ff;
      high_fit_in    = high_fit_ff;
      phase_in       = phase_ff;
      pending_low_in = pending_low_ff;
      probe_in       = '0;
      best_pt_in     = '0;
      best_fit_in    = '0;
      best_valid_in  = 1'b0;
      ignored_in     = 1'b0;

      cur_low_fit  = pending_low_ff ? item_fitness : low_fit_ff;
      cur_high_fit = pending_low_ff ? high_fit_ff : item_fitness;
      low_wins     = cur_low_fit < cur_high_fit;

      if (item.mode == MODE_START) begin
         lower_in       = dom_lo;
         upper_in       = dom_hi;
         low_probe_in   = start_low;
         high_probe_in  = start_high;
         low_fit_in     = FIT_MAX;
         high_fit_in    = FIT_MAX;
         pending_low_in = 1'b1;
         phase_in       = PH_FIRST;
         probe_in       = start_low;
      end else begin
         case (phase_ff)
            PH_FIRST: begin
               low_fit_in     = item_fitness;
               pending_low_in = 1'b0;
               phase_in       = PH_RUN;
               probe_in       = high_probe_ff;
            end
            PH_RUN: begin
               best_valid_in = 1'b1;
               if (low_wins) begin
                  best_pt_in     = low_probe_ff;
                  best_fit_in    = cur_low_fit;
                  upper_in       = high_probe_ff;
                  high_probe_in  = low_probe_ff;
                  low_fit_in     = cur_low_fit;
                  high_fit_in    = cur_low_fit;
                  low_probe_in   = run_low;
                  pending_low_in = 1'b1;
                  probe_in       = run_low;
               end else begin
                  best_pt_in     = high_probe_ff;
                  best_fit_in    = cur_high_fit;
                  lower_in       = low_probe_ff;
                  low_probe_in   = high_probe_ff;
                  low_fit_in     = cur_high_fit;
                  high_fit_in    = cur_high_fit;
                  high_probe_in  = run_high;
                  pending_low_in = 1'b0;
                  probe_in       = run_high;
               end
            end
            default: begin
               ignored_in = 1'b1;
            end
         endcase
      end
   end

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         domain_min_ff <= DOMAIN_MIN_RESET;
         domain_max_ff <= DOMAIN_MAX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOMAIN_MIN: domain_min_ff <= csr_wdata;
            CSR_DOMAIN_MAX: domain_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the search state on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff       <= '0;
         upper_ff       <= '0;
         low_probe_ff   <= '0;
         high_probe_ff  <= '0;
         low_fit_ff     <= FIT_MAX;
         high_fit_ff    <= FIT_MAX;
         phase_ff       <= PH_IDLE;
         pending_low_ff <= 1'b1;
      end else if (take) begin
         lower_ff       <= lower_in;
         upper_ff       <= upper_in;
         low_probe_ff   <= low_probe_in;
         high_probe_ff  <= high_probe_in;
         low_fit_ff     <= low_fit_in;
         high_fit_ff    <= high_fit_in;
         phase_ff       <= phase_in;
         pending_low_ff <= pending_low_in;
      end
   end

   // Result valid: set on processing, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         probe_ff      <= probe_in;
         best_pt_ff    <= best_pt_in;
         best_fit_ff   <= best_fit_in;
         best_valid_ff <= best_valid_in;
         ignored_ff    <= ignored_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probe_point    = probe_ff;
   assign rsp_best_point     = best_pt_ff;
   assign rsp_best_fitness   = best_fit_ff;
   assign rsp_best_valid     = best_valid_ff;
   assign rsp_report_ignored = ignored_ff;

endmodule

// File: src/golden_section_search_controller_core.sv
// ----------------------------------------------------------------------------
// golden_section_search_controller_core
// Golden-section minimum search: hands out probe points and takes back one
// fitness per probe, narrowing the bracket towards the lower fitness.
//
//   channel  direction  tdata                         tuser
//   req_     in         fitness                       mode
//   rsp_     out        probe, best_point, best_fit   best_valid, report_ignored
//   csr_     in         write of domain_min / domain_max (index 0 / 1)
//
// One transaction a cycle sustained while rsp_tready stays high; an item goes
// from the input register through the step stage into the result register.
// The path between them is one span multiply by a Q0.16 constant and an add.
// Reset is synchronous: registers return to their reset values, search idle.
// A stalled result holds the step stage; the input register takes one more
// transaction before req_tready drops.
// ----------------------------------------------------------------------------
module golden_section_search_controller_core #(
   parameter int POINT_WIDTH   = 32,
   parameter int FITNESS_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [gss_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gss_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   // input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: fitness, zero padding
   input  logic [((FITNESS_WIDTH+7)/8)*8-1:0]  req_tdata,
   // tuser: mode
   input  logic                                req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: probe_point, best_point, best_fitness, zero padding
   output logic [((2*POINT_WIDTH+FITNESS_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // tuser: best_valid, report_ignored
   output logic [1:0]                          rsp_tuser
);
   import gss_pkg::*;

   item_ctrl_type                   item;
   logic signed [FITNESS_WIDTH-1:0] item_fitness;
   logic                            take;
   logic signed [POINT_WIDTH-1:0]   probe_point, best_point;
   logic signed [FITNESS_WIDTH-1:0] best_fitness;
   logic                            best_valid, report_ignored;

   gss_in_stage #(.FITNESS_WIDTH(FITNESS_WIDTH)) u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_mode      (req_tuser),
      .in_fitness   (req_tdata[FITNESS_WIDTH-1:0]),
      .take         (take),
      .item         (item),
      .item_fitness (item_fitness)
   );

   gss_step #(.POINT_WIDTH(POINT_WIDTH), .FITNESS_WIDTH(FITNESS_WIDTH)) u_step (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .item               (item),
      .item_fitness       (item_fitness),
      .take               (take),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_probe_point    (probe_point),
      .rsp_best_point     (best_point),
      .rsp_best_fitness   (best_fitness),
      .rsp_best_valid     (best_valid),
      .rsp_report_ignored (report_ignored)
   );

   // Pack the result fields, lowest first
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[POINT_WIDTH-1:0]               = probe_point;
      rsp_tdata[2*POINT_WIDTH-1:POINT_WIDTH]   = best_point;
      rsp_tdata[2*POINT_WIDTH+FITNESS_WIDTH-1:2*POINT_WIDTH] = best_fitness;
      rsp_tuser = {report_ignored, best_valid};
   end

   // An ignored report never carries a measured best
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(best_valid && report_ignored))
      else $error("best_valid and report_ignored both set");

   // An ignored report returns all-zero payload
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && report_ignored) |-> (rsp_tdata == '0))
      else $error("ignored report carries non-zero payload");

   // Without a valid best the best fields stay zero
   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !best_valid) |-> (best_point == '0 && best_fitness == '0))
      else $error("best fields set without best_valid");

   // The step stage only processes when the input register holds an item
   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> item.valid)
      else $error("step stage took an empty slot");

endmodule

// File: bench/tb_golden_section_search_controller_core.sv
// ----------------------------------------------------------------------------
// tb_golden_section_search_controller_core
// Self-checking bench for the golden-section search controller. A directed
// table covers idle reports, extreme fitness values, restarts, full-range,
// reversed and zero-width domains. A long random run then follows, made of
// search sequences driven by a cost around a random target. Every result is
// checked against its table entry or a cycle-free search model, with random
// idling on both stream sides, one long result hold-off backing up the input.
// ----------------------------------------------------------------------------
module tb_golden_section_search_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gss_pkg::*;

   localparam int POINT_W        = 32;
   localparam int FIT_W          = 32;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int TAIL_ITEMS     = 150;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic signed [FIT_W-1:0] FIT_MAX = 32'sh7FFF_FFFF;

   // One result of the search, unpacked from the result channel
   typedef struct packed {
      logic [POINT_W-1:0] probe;
      logic [POINT_W-1:0] best_pt;
      logic [FIT_W-1:0]   best_fit;
      logic               best_ok;
      logic               ignored;
   } search_result_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_ITEM,
      ROW_CHECKED
   } row_kind_type;

   // sel is the mode of an item or the index of a register write
   typedef struct packed {
      row_kind_type      kind;
      logic              sel;
      logic [31:0]       value;
      search_result_type want;
   } dir_row_type;

   localparam search_result_type NO_RESULT  = '0;
   localparam search_result_type RES_IGNORE = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
   localparam search_result_type RES_LOW0   = '{32'd25032, 32'd0, 32'd0, 1'b0, 1'b0};
   localparam search_result_type RES_HIGH0  = '{32'd40504, 32'd0, 32'd0, 1'b0, 1'b0};
   localparam search_result_type RES_FLAT   = '{32'h1234_0000, 32'd0, 32'd0, 1'b0, 1'b0};
   localparam search_result_type RES_FLAT_T =
      '{32'h1234_0000, 32'h1234_0000, 32'd7, 1'b1, 1'b0};

   localparam int DIRECTED_COUNT = 29;
   localparam dir_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      // reports before any start are ignored
      '{ROW_CHECKED, MODE_REPORT, 32'h7FFF_FFFF, RES_IGNORE},
      '{ROW_CHECKED, MODE_REPORT, 32'h8000_0000, RES_IGNORE},
      // reset domain 0 .. 1.0
      '{ROW_CHECKED, MODE_START,  32'hFFFF_FFFF, RES_LOW0},
      '{ROW_CHECKED, MODE_REPORT, 32'd100,       RES_HIGH0},
      '{ROW_ITEM,    MODE_REPORT, 32'd200,       NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h8000_0000, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h7FFF_FFFF, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h7FFF_FFFF, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h7FFF_FFFF, NO_RESULT},
      // restart in the middle of a search
      '{ROW_CHECKED, MODE_START,  32'd0,         RES_LOW0},
      '{ROW_ITEM,    MODE_REPORT, 32'h8000_0000, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h8000_0000, NO_RESULT},
      // widest domain
      '{ROW_WRITE,   CSR_DOMAIN_MIN, 32'h8000_0000, NO_RESULT},
      '{ROW_WRITE,   CSR_DOMAIN_MAX, 32'h7FFF_FFFF, NO_RESULT},
      '{ROW_ITEM,    MODE_START,  32'h5A5A_5A5A, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'd3,         NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'd1,         NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'd2,         NO_RESULT},
      // reversed domain
      '{ROW_WRITE,   CSR_DOMAIN_MIN, 32'h7FFF_FFFF, NO_RESULT},
      '{ROW_WRITE,   CSR_DOMAIN_MAX, 32'h8000_0000, NO_RESULT},
      '{ROW_ITEM,    MODE_START,  32'hA5A5_A5A5, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'hFFFF_FFFF, NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'd0,         NO_RESULT},
      '{ROW_ITEM,    MODE_REPORT, 32'h8000_0000, NO_RESULT},
      // zero-width domain, then a tie that narrows from below
      '{ROW_WRITE,   CSR_DOMAIN_MIN, 32'h1234_0000, NO_RESULT},
      '{ROW_WRITE,   CSR_DOMAIN_MAX, 32'h1234_0000, NO_RESULT},
      '{ROW_CHECKED, MODE_START,  32'd0,         RES_FLAT},
      '{ROW_CHECKED, MODE_REPORT, 32'd7,         RES_FLAT},
      '{ROW_CHECKED, MODE_REPORT, 32'd7,         RES_FLAT_T}
   };

   localparam logic [31:0] FIT_EDGES [0:3] =
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [CSR_INDEX_WIDTH-1:0]          csr_index;
   logic [CSR_DATA_WIDTH-1:0]           csr_wdata;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [31:0]                         req_tdata;
   logic                                req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [95:0]                         rsp_tdata;
   logic [1:0]                          rsp_tuser;

   // Model state of the search and its copy of the domain registers
   logic signed [POINT_W-1:0] dom_min, dom_max;
   logic signed [POINT_W-1:0] srch_lower, srch_upper, srch_lo_pt, srch_hi_pt;
   logic signed [FIT_W-1:0]   srch_lo_fit, srch_hi_fit;
   phase_type                 srch_phase;
   logic                      srch_pend_low;

   search_result_type         expected_results [$];
   logic signed [POINT_W-1:0] last_probe;
   int                        items_taken;
   int                        results_seen;
   int                        mismatches;
   int                        gap_pct;
   logic                      quiet_tail;

   golden_section_search_controller_core #(
      .POINT_WIDTH   (POINT_W),
      .FITNESS_WIDTH (FIT_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Point at fraction k (Q0.16) of the way from lo towards hi, product truncated
   function automatic logic signed [POINT_W-1:0] golden_point(
      logic signed [POINT_W-1:0] lo, logic signed [POINT_W-1:0] hi,
      logic [GOLD_K_WIDTH-1:0] k);
      logic [POINT_W-1:0] mag;
      logic [63:0]        prod;
      mag = (hi < lo) ? lo - hi : hi - lo;
      prod = {32'd0, mag} * {48'd0, k};
      return (hi < lo) ? lo - prod[47:16] : lo + prod[47:16];
   endfunction

   // Advance the search model by one accepted item and return its result
   function automatic search_result_type advance_search(logic mode, logic [FIT_W-1:0] fit);
      search_result_type r;
      logic              low_wins;
      r = '0;
      if (mode == MODE_START) begin
         srch_lower    = dom_min;
         srch_upper    = dom_max;
         srch_lo_pt    = golden_point(srch_lower, srch_upper, GOLD_K_LOW);
         srch_hi_pt    = golden_point(srch_lower, srch_upper, GOLD_K_HIGH);
         srch_lo_fit   = FIT_MAX;
         srch_hi_fit   = FIT_MAX;
         srch_pend_low = 1'b1;
         srch_phase    = PH_FIRST;
         r.probe       = srch_lo_pt;
      end else if (srch_phase == PH_FIRST) begin
         srch_lo_fit   = fit;
         srch_pend_low = 1'b0;
         srch_phase    = PH_RUN;
         r.probe       = srch_hi_pt;
      end else if (srch_phase == PH_RUN) begin
         if (srch_pend_low) begin
            srch_lo_fit = fit;
         end else begin
            srch_hi_fit = fit;
         end
         // the low side must win strictly; a tie narrows from below
         low_wins   = srch_lo_fit < srch_hi_fit;
         r.best_pt  = low_wins ? srch_lo_pt : srch_hi_pt;
         r.best_fit = low_wins ? srch_lo_fit : srch_hi_fit;
         r.best_ok  = 1'b1;
         if (low_wins) begin
            srch_upper    = srch_hi_pt;
            srch_hi_pt    = srch_lo_pt;
            srch_hi_fit   = srch_lo_fit;
            srch_lo_pt    = golden_point(srch_lower, srch_upper, GOLD_K_LOW);
            srch_pend_low = 1'b1;
            r.probe       = srch_lo_pt;
         end else begin
            srch_lower    = srch_lo_pt;
            srch_lo_pt    = srch_hi_pt;
            srch_lo_fit   = srch_hi_fit;
            srch_hi_pt    = golden_point(srch_lower, srch_upper, GOLD_K_HIGH);
            srch_pend_low = 1'b0;
            r.probe       = srch_hi_pt;
         end
      end else begin
         r.ignored = 1'b1;
      end
      return r;
   endfunction

   // Cost of the pending probe: mostly distance to target, with ties and noise
   function automatic logic [FIT_W-1:0] pick_fitness(logic signed [POINT_W-1:0] target);
      logic signed [POINT_W-1:0] span_off;
      span_off = last_probe - target;
      if (span_off < 0) begin
         span_off = -span_off;
      end
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return srch_pend_low ? srch_hi_fit : srch_lo_fit;
         3:       return FIT_EDGES[$urandom_range(0, 3)];
         4:       return (span_off >>> 8) + $urandom_range(0, 3);
         default: return span_off;
      endcase
   endfunction

   // Offer one item; on acceptance record its expected result.
   // Entered and left on a falling edge.
   task automatic offer_item(logic mode, logic [FIT_W-1:0] fit, logic use_fixed,
                             search_result_type fixed);
      search_result_type pred;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= fit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = advance_search(mode, fit);
      expected_results.push_back(use_fixed ? fixed : pred);
      last_probe = pred.probe;
      items_taken++;
      @(negedge clock);
   endtask

   // Hold the input and wait until every result is back and the block is quiet
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_DOMAIN_MIN) begin
         dom_min = val;
      end else begin
         dom_max = val;
      end
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Stimulus: reset, directed table, then random search sequences
   initial begin
      int                        rand_goal;
      int                        reports;
      logic [31:0]               new_min, new_max;
      logic signed [POINT_W-1:0] target;
      dir_row_type               row;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      dom_min       = DOMAIN_MIN_RESET;
      dom_max       = DOMAIN_MAX_RESET;
      srch_lower    = '0;
      srch_upper    = '0;
      srch_lo_pt    = '0;
      srch_hi_pt    = '0;
      srch_lo_fit   = FIT_MAX;
      srch_hi_fit   = FIT_MAX;
      srch_phase    = PH_IDLE;
      srch_pend_low = 1'b1;
      last_probe    = '0;
      items_taken   = 0;
      gap_pct       = 20;
      quiet_tail    = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            settle_block();
            write_reg(row.sel, row.value);
         end else begin
            offer_item(row.sel, row.value, row.kind == ROW_CHECKED, row.want);
         end
      end

      // Random search sequences, each after an optional random rewrite of either domain register
      rand_goal = items_taken + RANDOM_ITEMS;
      while (items_taken < rand_goal) begin
         settle_block();
         case ($urandom_range(0, 5))
            0: begin
               new_min = $urandom;
               new_max = $urandom;
            end
            1: begin
               new_min = $urandom;
               new_max = new_min + $urandom_range(1, 1 << 20);
            end
            2: begin
               new_min = 32'h8000_0000;
               new_max = 32'h7FFF_FFFF;
            end
            3: begin
               new_min = 32'h7FFF_FFFF;
               new_max = 32'h8000_0000;
            end
            4: begin
               new_min = $urandom;
               new_max = new_min;
            end
            default: begin
               new_min = -(32'd65536 * $urandom_range(0, 100));
               new_max = 32'd65536 * $urandom_range(1, 100);
            end
         endcase
         if ($urandom_range(0, 4) != 0) begin
            write_reg(CSR_DOMAIN_MIN, new_min);
         end
         if ($urandom_range(0, 4) != 0) begin
            write_reg(CSR_DOMAIN_MAX, new_max);
         end
         target = golden_point(dom_min, dom_max, GOLD_K_WIDTH'($urandom_range(0, 65535)));
         if (items_taken >= rand_goal - TAIL_ITEMS) begin
            quiet_tail = 1'b1;
            gap_pct    = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 15;
               default: gap_pct = 50;
            endcase
         end
         offer_item(MODE_START, $urandom, 1'b0, NO_RESULT);
         reports = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom_range(8, 40);
         for (int n = 0; n < reports; n++) begin
            // break the odd sequence with a restart
            if ($urandom_range(0, 19) == 0) begin
               offer_item(MODE_START, $urandom, 1'b0, NO_RESULT);
            end else begin
               offer_item(MODE_REPORT, pick_fitness(target), 1'b0, NO_RESULT);
            end
         end
      end

      // Drain and let any stray result show up
      settle_block();
      repeat (12) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("golden_section_search_controller_core: match");
      end else begin
         $display("golden_section_search_controller_core: mismatch");
      end
      $finish;
   end

   // Result side: random stalls, one long hold-off to back up the input
   initial begin
      logic pressure_done;
      pressure_done = 1'b0;
      rsp_tready    = 1'b0;
      @(negedge clock);
      forever begin
         if (!pressure_done && items_taken >= 200) begin
            pressure_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      search_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                 rsp_tuser[0], rsp_tuser[1]};
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d with nothing expected: probe %h best %h fit %h ok %b ign %b",
                        results_seen, got.probe, got.best_pt, got.best_fit,
                        got.best_ok, got.ignored);
            end
         end else begin
            want = expected_results.pop_front();
            if (got.probe !== want.probe || got.best_pt !== want.best_pt ||
                got.best_fit !== want.best_fit || got.best_ok !== want.best_ok ||
                got.ignored !== want.ignored) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: expected probe %h best %h fit %h ok %b ign %b",
                           results_seen, want.probe, want.best_pt, want.best_fit,
                           want.best_ok, want.ignored);
                  $display("            got      probe %h best %h fit %h ok %b ign %b",
                           got.probe, got.best_pt, got.best_fit, got.best_ok, got.ignored);
               end
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   initial begin
      int quiet_cycles;
      results_seen = 0;
      mismatches   = 0;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("golden_section_search_controller_core: mismatch");
      $finish;
   end

endmodule

// File: golden_section_search_controller_core.f
src/gss_pkg.sv
src/gss_golden.sv
src/gss_in_stage.sv
src/gss_step.sv
src/golden_section_search_controller_core.sv
bench/tb_golden_section_search_controller_core.sv
